### rtl/core/particle_frame_deframer_defines.svh
// ----------------------------------------------------------------------------
// particle_frame_deframer_defines
// assertion macros used by the deframer queue
// ----------------------------------------------------------------------------
`ifndef PARTICLE_FRAME_DEFRAMER_DEFINES_SVH
`define PARTICLE_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTH
// clocked check, held off while reset is low
`define PFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define PFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define PFD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg
// types and constants of the particle frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package pfd_pkg;

    // frame geometry
    localparam int RECORDS    = 1024;
    localparam int REC_END_I  = 8 + 8 * RECORDS;
    localparam int LAST_I     = REC_END_I + 3;
    localparam int POS_W      = $clog2(LAST_I + 1);

    localparam logic [POS_W-1:0] POS_CHAN_LAST = POS_W'(7);
    localparam logic [POS_W-1:0] POS_REC_FIRST = POS_W'(8);
    localparam logic [POS_W-1:0] POS_REC_END   = POS_W'(REC_END_I);
    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(LAST_I);

    // stream constants
    localparam logic [7:0]  PARTICLE_MODE = 8'h05;
    localparam logic [31:0] HEADER_WORD   = 32'h0000_AAB3;
    localparam logic [31:0] TRAILER_WORD  = 32'h0000_CCD3;

    // queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_CHANNEL = 2'd0,
        KIND_RECORD  = 2'd1,
        KIND_VERDICT = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] data;
        logic [9:0]  idx;
        logic        good;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

### rtl/core/pfd_front.sv
// ----------------------------------------------------------------------------
// pfd_front
// takes stream bytes, hunts headers, tracks the frame and queues results
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_front
    import pfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [7:0]  i_transfer_mode,
    input  wire logic        i_in_valid,
    input  wire logic [7:0]  i_rx_byte,
    input  wire t_q_status   i_q_status,
    output logic             o_in_stall,
    output logic             o_push,
    output t_entry           o_entry
);

    logic [7:0]       r_mode;
    logic             r_in_frame, n_in_frame;
    logic [31:0]      r_window, n_window;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [63:0]      r_asm, n_asm;

    logic             accept;
    logic [POS_W-1:0] off;
    logic [POS_W+9:0] rec_wide;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;
    assign off        = r_pos - POS_REC_FIRST;
    assign rec_wide   = {10'd0, off} >> 3;

    // mode register, to be written only while idle; the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 8'd0;
        end else if (i_cfg_valid) begin
            r_mode <= i_transfer_mode;
        end
    end

    // parser next state and result classification
    always_comb begin
        n_in_frame = r_in_frame;
        n_window   = r_window;
        n_pos      = r_pos;
        n_asm      = r_asm;
        o_push     = 1'b0;
        o_entry    = '0;
        if (accept) begin
            if (r_mode != PARTICLE_MODE) begin
                n_in_frame = 1'b0;
                n_window   = '0;
                n_pos      = '0;
                n_asm      = '0;
            end else begin
                n_window = {r_window[23:0], i_rx_byte};
                if (!r_in_frame) begin
                    if (n_window == HEADER_WORD) begin
                        n_in_frame = 1'b1;
                        n_pos      = '0;
                        n_asm      = '0;
                    end
                end else begin
                    n_asm = {r_asm[55:0], i_rx_byte};
                    n_pos = r_pos + 1'b1;
                    if (r_pos == POS_CHAN_LAST) begin
                        o_push       = 1'b1;
                        o_entry.kind = KIND_CHANNEL;
                        o_entry.data = n_asm;
                    end else if (r_pos >= POS_REC_FIRST && r_pos < POS_REC_END) begin
                        if (off[2:0] == 3'b111) begin
                            o_push       = 1'b1;
                            o_entry.kind = KIND_RECORD;
                            o_entry.data = n_asm;
                            o_entry.idx  = rec_wide[9:0];
                        end
                    end else if (r_pos >= POS_LAST) begin
                        // trailer done: verdict and back to hunting
                        o_push       = 1'b1;
                        o_entry.kind = KIND_VERDICT;
                        o_entry.good = (n_window == TRAILER_WORD);
                        n_in_frame   = 1'b0;
                        n_window     = '0;
                        n_pos        = '0;
                        n_asm        = '0;
                    end
                end
            end
        end
    end

    // parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_window   <= '0;
            r_pos      <= '0;
            r_asm      <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_window   <= n_window;
            r_pos      <= n_pos;
            r_asm      <= n_asm;
        end
    end

endmodule

`default_nettype wire

### rtl/core/pfd_queue.sv
// ----------------------------------------------------------------------------
// pfd_queue
// short result queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

`include "particle_frame_deframer_defines.svh"

module pfd_queue
    import pfd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_wr_entry,
    input  wire logic   i_pop,
    output t_entry      o_rd_entry,
    output t_q_status   o_status
);

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_status.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_rd_entry     = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // queue sanity
    `PFD_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_status.full), "push into full queue")
    `PFD_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_status.empty), "pop from empty queue")
    `PFD_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= QCNT_W'(QDEPTH), "queue level out of range")
    `PFD_ASSERT(a_pop_drains, i_clk, i_rst_n, (i_pop && !i_push) |=> (r_count == $past(r_count) - 1'b1), "level not lowered by pop")

endmodule

`default_nettype wire

### rtl/core/pfd_back.sv
// ----------------------------------------------------------------------------
// pfd_back
// drains the queue and formats result requests into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_back
    import pfd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_entry    i_entry,
    input  wire t_q_status i_q_status,
    output logic           o_pop,
    input  wire logic      i_out_stall,
    output logic           o_out_valid,
    output logic [1:0]     o_result_kind,
    output logic [63:0]    o_channel_word,
    output logic [47:0]    o_event_time,
    output logic [15:0]    o_energy,
    output logic [9:0]     o_record_index,
    output logic           o_frame_good
);

    logic        r_valid;
    logic [1:0]  r_kind;
    logic [63:0] r_chan;
    logic [47:0] r_time;
    logic [15:0] r_energy;
    logic [9:0]  r_idx;
    logic        r_good;

    assign o_pop = !i_q_status.empty && (!r_valid || !i_out_stall);

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // output payload, unused fields read zero
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind   <= i_entry.kind;
            r_chan   <= (i_entry.kind == KIND_CHANNEL) ? i_entry.data : 64'd0;
            r_time   <= (i_entry.kind == KIND_RECORD) ? i_entry.data[63:16] : 48'd0;
            r_energy <= (i_entry.kind == KIND_RECORD) ? i_entry.data[15:0] : 16'd0;
            r_idx    <= (i_entry.kind == KIND_RECORD) ? i_entry.idx : 10'd0;
            r_good   <= (i_entry.kind == KIND_VERDICT) ? i_entry.good : 1'b0;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_result_kind  = r_kind;
    assign o_channel_word = r_chan;
    assign o_event_time   = r_time;
    assign o_energy       = r_energy;
    assign o_record_index = r_idx;
    assign o_frame_good   = r_good;

endmodule

`default_nettype wire

### rtl/core/particle_frame_deframer.sv
// ----------------------------------------------------------------------------
// particle_frame_deframer
// byte-serial deframer for the detector particle stream
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// input    in         i_in_valid/o_in_stall   i_rx_byte
// config   in         i_cfg_valid/o_cfg_ready i_transfer_mode
// output   out        o_out_valid/i_out_stall o_result_kind .. o_frame_good
//
// one byte is taken every cycle unless the queue is full; the parser
// state updates in a single step; a result is written into the queue when
// its last byte is taken and reaches the output register once it is free
// a four-entry queue separates the parser from the output register, so the
// input stalls only once the queue is full under a stalled output
// reset is synchronous, active low, and clears parser, queue and mode
// ----------------------------------------------------------------------------
`default_nettype none

module particle_frame_deframer
    import pfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_transfer_mode,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_result_kind,
    output logic [63:0]      o_channel_word,
    output logic [47:0]      o_event_time,
    output logic [15:0]      o_energy,
    output logic [9:0]       o_record_index,
    output logic             o_frame_good
);

    t_q_status q_status;
    t_entry    wr_entry, rd_entry;
    logic      push, pop;

    assign o_cfg_ready = 1'b1;

    // front: header hunt and frame tracking
    pfd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_transfer_mode (i_transfer_mode),
        .i_in_valid      (i_in_valid),
        .i_rx_byte       (i_rx_byte),
        .i_q_status      (q_status),
        .o_in_stall      (o_in_stall),
        .o_push          (push),
        .o_entry         (wr_entry)
    );

    // result queue
    pfd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_wr_entry (wr_entry),
        .i_pop      (pop),
        .o_rd_entry (rd_entry),
        .o_status   (q_status)
    );

    // back: result formatting and output register
    pfd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry        (rd_entry),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_result_kind  (o_result_kind),
        .o_channel_word (o_channel_word),
        .o_event_time   (o_event_time),
        .o_energy       (o_energy),
        .o_record_index (o_record_index),
        .o_frame_good   (o_frame_good)
    );

endmodule

`default_nettype wire
